// ----- design/gffp_pkg.sv -----
// Shared types and constants for the grid first-fit placer.
// Used by gffp_ctrl, gffp_dp and grid_first_fit_placer_core.
package gffp_pkg;

    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 32;
    localparam int MAX_PIECES_DEF = 16;

    localparam int ID_W     = 8;
    localparam int LEN_W    = 6;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 2;
    localparam int ROW_OUT_W = 6;
    localparam int COL_OUT_W = 5;

    localparam int RW_W     = 6;
    localparam int RC_W     = 7;
    localparam int CFG_DW   = 7;
    localparam int CFG_IW   = 1;

    localparam logic [RW_W-1:0] ROW_WIDTH_RST = 6'd20;
    localparam logic [RC_W-1:0] ROW_COUNT_RST = 7'd50;

    localparam logic [CFG_IW-1:0] CFG_ROW_WIDTH = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_ROW_COUNT = 1'd1;

    localparam logic [STATUS_W-1:0] ST_PLACED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_WIDE  = 2'd2;

    typedef struct packed {
        logic clear_en;
        logic load_req;
        logic scan_init;
        logic scan_en;
        logic fill_en;
        logic emit;
    } gffp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic req_none;
        logic req_wide;
        logic req_nofit;
        logic found;
        logic scan_end;
        logic fill_last;
        logic out_free;
        logic last_piece;
    } gffp_sts_t;

endpackage

// ----- design/gffp_ctrl.sv -----
// Controller state machine of the grid first-fit placer.
// Depends on gffp_pkg; drives gffp_dp through gffp_cmd_t.
module gffp_ctrl
    import gffp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  gffp_sts_t sts,
    output gffp_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.scan_init = 1'b1;
                if (sts.req_none) begin
                    state_next = S_IDLE;
                end else if (sts.req_wide || sts.req_nofit) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_en = 1'b1;
                if (sts.found) begin
                    state_next = S_FILL;
                end else if (sts.scan_end) begin
                    state_next = S_EMIT;
                end
            end
            S_FILL: begin
                cmd.fill_en = 1'b1;
                if (sts.fill_last) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.req_wide || sts.last_piece) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ----- design/gffp_dp.sv -----
// Datapath of the grid first-fit placer: cell memory, scan and fill counters,
// configuration registers and result register. Depends on gffp_pkg.
module gffp_dp
    import gffp_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_PIECES = MAX_PIECES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IW-1:0]     cfg_index,
    input  logic [CFG_DW-1:0]     cfg_data,
    input  logic [ID_W-1:0]       s_item_id,
    input  logic [LEN_W-1:0]      s_run_length,
    input  logic [CNT_W-1:0]      s_piece_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ROW_OUT_W-1:0]  m_row_index,
    output logic [COL_OUT_W-1:0]  m_start_column,
    output logic                  m_last_result,
    input  gffp_cmd_t             cmd,
    output gffp_sts_t             sts
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_NW = $clog2(MAX_ROWS + 1);
    localparam int COL_NW = $clog2(MAX_COLS + 1);
    localparam int PC_W   = $clog2(MAX_PIECES + 1);

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;
    logic            mem_we;
    logic            mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [ID_W-1:0] mem_wdata;

    logic [RW_W-1:0] row_width_reg;
    logic [RC_W-1:0] row_count_reg;

    logic [ADDR_W-1:0] clr_reg, clr_next;

    logic [ID_W-1:0]   id_reg, id_next;
    logic [COL_NW-1:0] len_reg, len_next;
    logic [PC_W-1:0]   left_reg, left_next;
    logic              wide_reg, wide_next;
    logic              nofit_reg, nofit_next;
    logic [ROW_IW-1:0] rows_last_reg, rows_last_next;
    logic [COL_IW-1:0] cols_last_reg, cols_last_next;

    logic              issue_on_reg, issue_on_next;
    logic [ROW_IW-1:0] ir_reg, ir_next;
    logic [COL_IW-1:0] ic_reg, ic_next;
    logic              dv_reg, dv_next;
    logic [ROW_IW-1:0] dr_reg, dr_next;
    logic [COL_IW-1:0] dc_reg, dc_next;
    logic [COL_NW-1:0] run_reg, run_next;

    logic              placed_reg, placed_next;
    logic [ROW_IW-1:0] found_row_reg, found_row_next;
    logic [COL_IW-1:0] found_col_reg, found_col_next;
    logic [COL_IW-1:0] fill_col_reg, fill_col_next;
    logic [COL_NW-1:0] fill_left_reg, fill_left_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [ROW_OUT_W-1:0] m_row_reg, m_row_next;
    logic [COL_OUT_W-1:0] m_col_reg, m_col_next;
    logic                 m_last_reg, m_last_next;

    logic [COL_NW-1:0] cols_eff;
    logic [ROW_NW-1:0] rows_eff;
    logic [PC_W-1:0]   cnt_eff;
    logic [COL_NW-1:0] run_in;
    logic [COL_NW-1:0] run_new;
    logic [COL_NW-1:0] start_full;
    logic              hit;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RST;
            row_count_reg <= ROW_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROW_WIDTH: row_width_reg <= cfg_data[RW_W-1:0];
                CFG_ROW_COUNT: row_count_reg <= cfg_data[RC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cols_eff = (row_width_reg > MAX_COLS) ? COL_NW'(MAX_COLS) : COL_NW'(row_width_reg);
        rows_eff = (row_count_reg > MAX_ROWS) ? ROW_NW'(MAX_ROWS) : ROW_NW'(row_count_reg);
        cnt_eff  = (s_piece_count > MAX_PIECES) ? PC_W'(MAX_PIECES) : PC_W'(s_piece_count);

        run_in     = (dc_reg == '0) ? '0 : run_reg;
        run_new    = (rd_data_reg == '0) ? run_in + 1'b1 : '0;
        hit        = (run_new == len_reg);
        start_full = COL_NW'(dc_reg) + COL_NW'(1) - len_reg;

        clr_next       = clr_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        wide_next      = wide_reg;
        nofit_next     = nofit_reg;
        rows_last_next = rows_last_reg;
        cols_last_next = cols_last_reg;
        issue_on_next  = issue_on_reg;
        ir_next        = ir_reg;
        ic_next        = ic_reg;
        dv_next        = dv_reg;
        dr_next        = dr_reg;
        dc_next        = dc_reg;
        run_next       = run_reg;
        placed_next    = placed_reg;
        found_row_next = found_row_reg;
        found_col_next = found_col_reg;
        fill_col_next  = fill_col_reg;
        fill_left_next = fill_left_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_status_next  = m_status_reg;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_last_next    = m_last_reg;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = ADDR_W'(int'(ir_reg) * MAX_COLS + int'(ic_reg));
        mem_wdata = id_reg;

        sts            = '0;
        sts.clear_done = (clr_reg == ADDR_W'(DEPTH - 1));
        sts.req_none   = (left_reg == '0);
        sts.req_wide   = wide_reg;
        sts.req_nofit  = nofit_reg;
        sts.fill_last  = (fill_left_reg == COL_NW'(1));
        sts.out_free   = ~m_valid_reg | m_ready;
        sts.last_piece = (left_reg == PC_W'(1));

        if (cmd.clear_en) begin
            mem_we    = 1'b1;
            mem_addr  = clr_reg;
            mem_wdata = '0;
            clr_next  = clr_reg + 1'b1;
        end

        if (cmd.load_req) begin
            id_next        = s_item_id;
            len_next       = COL_NW'(s_run_length);
            left_next      = cnt_eff;
            wide_next      = (s_run_length > cols_eff);
            nofit_next     = (s_run_length == '0) || (rows_eff == '0);
            rows_last_next = ROW_IW'(rows_eff - 1'b1);
            cols_last_next = COL_IW'(cols_eff - 1'b1);
        end

        if (cmd.scan_init) begin
            issue_on_next = 1'b1;
            ir_next       = '0;
            ic_next       = '0;
            dv_next       = 1'b0;
            run_next      = '0;
            placed_next   = 1'b0;
        end

        if (cmd.scan_en) begin
            dv_next = issue_on_reg;
            if (issue_on_reg) begin
                mem_re  = 1'b1;
                dr_next = ir_reg;
                dc_next = ic_reg;
                if (ic_reg == cols_last_reg) begin
                    ic_next = '0;
                    if (ir_reg == rows_last_reg) begin
                        issue_on_next = 1'b0;
                    end else begin
                        ir_next = ir_reg + 1'b1;
                    end
                end else begin
                    ic_next = ic_reg + 1'b1;
                end
            end
            if (dv_reg) begin
                run_next = run_new;
                if (hit) begin
                    sts.found      = 1'b1;
                    placed_next    = 1'b1;
                    found_row_next = dr_reg;
                    found_col_next = start_full[COL_IW-1:0];
                    fill_col_next  = start_full[COL_IW-1:0];
                    fill_left_next = len_reg;
                end else if (dr_reg == rows_last_reg && dc_reg == cols_last_reg) begin
                    sts.scan_end = 1'b1;
                end
            end
        end

        if (cmd.fill_en) begin
            mem_we         = 1'b1;
            mem_addr       = ADDR_W'(int'(found_row_reg) * MAX_COLS + int'(fill_col_reg));
            fill_col_next  = fill_col_reg + 1'b1;
            fill_left_next = fill_left_reg - 1'b1;
        end

        row_ext = 32'(found_row_reg);
        col_ext = 32'(found_col_reg);
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            left_next    = left_reg - 1'b1;
            if (wide_reg) begin
                m_status_next = ST_TOO_WIDE;
                m_row_next    = '0;
                m_col_next    = '0;
                m_last_next   = 1'b1;
            end else begin
                m_status_next = placed_reg ? ST_PLACED : ST_NO_FIT;
                m_row_next    = placed_reg ? row_ext[ROW_OUT_W-1:0] : '0;
                m_col_next    = placed_reg ? col_ext[COL_OUT_W-1:0] : '0;
                m_last_next   = (left_reg == PC_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            issue_on_reg <= 1'b0;
            dv_reg       <= 1'b0;
            placed_reg   <= 1'b0;
            left_reg     <= '0;
            wide_reg     <= 1'b0;
            nofit_reg    <= 1'b0;
        end else begin
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
            issue_on_reg <= issue_on_next;
            dv_reg       <= dv_next;
            placed_reg   <= placed_next;
            left_reg     <= left_next;
            wide_reg     <= wide_next;
            nofit_reg    <= nofit_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg        <= id_next;
        len_reg       <= len_next;
        rows_last_reg <= rows_last_next;
        cols_last_reg <= cols_last_next;
        ir_reg        <= ir_next;
        ic_reg        <= ic_next;
        dr_reg        <= dr_next;
        dc_reg        <= dc_next;
        run_reg       <= run_next;
        found_row_reg <= found_row_next;
        found_col_reg <= found_col_next;
        fill_col_reg  <= fill_col_next;
        fill_left_reg <= fill_left_next;
        m_status_reg  <= m_status_next;
        m_row_reg     <= m_row_next;
        m_col_reg     <= m_col_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_row_index    = m_row_reg;
    assign m_start_column = m_col_reg;
    assign m_last_result  = m_last_reg;

endmodule

// ----- design/grid_first_fit_placer_core.sv -----
// Top level of the grid first-fit placer: controller plus datapath.
// Depends on gffp_pkg, gffp_ctrl and gffp_dp.
// Reset: a clearing pass zeroes all MAX_ROWS*MAX_COLS cells of the memory, no request taken.
// Per piece: a setup state, a scan of up to rows*cols cells, a fill of run_length cells and an emit
// state. Too wide, zero length or zero rows go from setup straight to emit, with no scan or fill.
// One request in work at a time; a stalled result holds it.
module grid_first_fit_placer_core
    import gffp_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int MAX_PIECES = MAX_PIECES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ID_W-1:0]      s_item_id,
    input  logic [LEN_W-1:0]     s_run_length,
    input  logic [CNT_W-1:0]     s_piece_count,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [ROW_OUT_W-1:0] m_row_index,
    output logic [COL_OUT_W-1:0] m_start_column,
    output logic                 m_last_result
);

    gffp_cmd_t cmd;
    gffp_sts_t sts;

    gffp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gffp_dp #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .MAX_PIECES (MAX_PIECES)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_item_id      (s_item_id),
        .s_run_length   (s_run_length),
        .s_piece_count  (s_piece_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_row_index    (m_row_index),
        .m_start_column (m_start_column),
        .m_last_result  (m_last_result),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

// ----- sim/tb_grid_first_fit_placer_core.sv -----
// Testbench for grid_first_fit_placer_core: directed and random placement requests
// with a cycle-free first-fit grid predictor, random idling on both channels.
// Depends on gffp_pkg and the placer RTL.
module tb_grid_first_fit_placer_core
    import gffp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 2200;

    typedef struct {
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 last;
    } placement_t;

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [CFG_IW-1:0]    cfg_index      = '0;
    logic [CFG_DW-1:0]    cfg_data       = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [ID_W-1:0]      s_item_id      = '0;
    logic [LEN_W-1:0]     s_run_length   = '0;
    logic [CNT_W-1:0]     s_piece_count  = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [ROW_OUT_W-1:0] m_row_index;
    logic [COL_OUT_W-1:0] m_start_column;
    logic                 m_last_result;

    request_t   pending_requests[$];
    placement_t expected_placements[$];
    logic [ID_W-1:0] grid_owner [MAX_ROWS_DEF][MAX_COLS_DEF];
    logic [RW_W-1:0] width_shadow = ROW_WIDTH_RST;
    logic [RC_W-1:0] count_shadow = ROW_COUNT_RST;

    int requests_queued = 0;
    int requests_taken  = 0;
    int error_count     = 0;
    int stalled_cycles  = 0;
    int gap_left        = 0;
    int stall_left      = 0;
    bit idle_on         = 1'b0;
    bit req_accepted    = 1'b0;

    grid_first_fit_placer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item_id      (s_item_id),
        .s_run_length   (s_run_length),
        .s_piece_count  (s_piece_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_row_index    (m_row_index),
        .m_start_column (m_start_column),
        .m_last_result  (m_last_result)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // First-fit placement of the pieces of one request on the shadow grid (one result if too wide).
    function automatic void predict_placements(request_t rq);
        int cols, rows, pieces, p, r, c, k, run, hit_row, hit_col;
        bit hit;
        placement_t res;
        cols   = (width_shadow > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(width_shadow);
        rows   = (count_shadow > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(count_shadow);
        pieces = (rq.cnt > MAX_PIECES_DEF) ? MAX_PIECES_DEF : int'(rq.cnt);
        if (pieces == 0)
            return;
        if (int'(rq.len) > cols) begin
            res.status = ST_TOO_WIDE;
            res.row    = '0;
            res.col    = '0;
            res.last   = 1'b1;
            expected_placements.push_back(res);
            return;
        end
        for (p = 0; p < pieces; p++) begin
            hit     = 1'b0;
            hit_row = 0;
            hit_col = 0;
            for (r = 0; r < rows && !hit && rq.len != 0; r++) begin
                run = 0;
                for (c = 0; c < cols && !hit; c++) begin
                    run = (grid_owner[r][c] == '0) ? run + 1 : 0;
                    if (run == int'(rq.len)) begin
                        hit     = 1'b1;
                        hit_row = r;
                        hit_col = c + 1 - int'(rq.len);
                        for (k = hit_col; k <= c; k++)
                            grid_owner[r][k] = rq.id;
                    end
                end
            end
            res.status = hit ? ST_PLACED : ST_NO_FIT;
            res.row    = ROW_OUT_W'(hit_row);
            res.col    = COL_OUT_W'(hit_col);
            res.last   = (p + 1 == pieces);
            expected_placements.push_back(res);
        end
    endfunction

    function automatic void add_request(int id, int len, int cnt);
        request_t rq;
        rq.id  = ID_W'(id);
        rq.len = LEN_W'(len);
        rq.cnt = CNT_W'(cnt);
        pending_requests.push_back(rq);
        requests_queued++;
    endfunction

    task automatic wait_idle();
        while (!(requests_taken == requests_queued && expected_placements.size() == 0))
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IW-1:0] idx, int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DW'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ROW_WIDTH)
            width_shadow = RW_W'(value);
        else
            count_shadow = RC_W'(value);
    endtask

    // Request driver
    always @(negedge aclk) begin
        request_t rq;
        if (!s_valid || req_accepted) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                rq = pending_requests.pop_front();
                s_valid       <= 1'b1;
                s_item_id     <= rq.id;
                s_run_length  <= rq.len;
                s_piece_count <= rq.cnt;
                if (idle_on && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 17);
            end else begin
                s_valid <= 1'b0;
            end
        end
        req_accepted = 1'b0;
    end

    // Result back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 17);
        end
    end

    // Monitor, predictor hook and watchdog
    always @(posedge aclk) begin
        request_t   seen;
        placement_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen.id  = s_item_id;
                seen.len = s_run_length;
                seen.cnt = s_piece_count;
                predict_placements(seen);
                req_accepted = 1'b1;
                requests_taken++;
            end
            if (m_valid && m_ready) begin
                if (expected_placements.size() == 0) begin
                    $error("unexpected result: status %0d row %0d column %0d last %0d",
                           m_status, m_row_index, m_start_column, m_last_result);
                    error_count++;
                end else begin
                    want = expected_placements.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        error_count++;
                    end
                    if (m_row_index !== want.row) begin
                        $error("row_index: expected %0d, actual %0d", want.row, m_row_index);
                        error_count++;
                    end
                    if (m_start_column !== want.col) begin
                        $error("start_column: expected %0d, actual %0d",
                               want.col, m_start_column);
                        error_count++;
                    end
                    if (m_last_result !== want.last) begin
                        $error("last_result: expected %0d, actual %0d",
                               want.last, m_last_result);
                        error_count++;
                    end
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int ph, k, sel, id, len, cnt, rows, cols;
        for (int r = 0; r < MAX_ROWS_DEF; r++)
            for (int c = 0; c < MAX_COLS_DEF; c++)
                grid_owner[r][c] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        idle_on = 1'b1;

        // Reset geometry: extremes, zero id, zero length, too wide, no pieces, saturation
        add_request(1, 1, 1);
        add_request(255, 20, 3);
        add_request(0, 5, 2);
        add_request(7, 0, 3);
        add_request(9, 21, 2);
        add_request(170, 63, 31);
        add_request(12, 3, 0);
        add_request(13, 2, 31);
        add_request(85, 1, 16);
        add_request(42, 19, 1);
        wait_idle();

        // Zero width, single row
        write_cfg(CFG_ROW_WIDTH, 0);
        write_cfg(CFG_ROW_COUNT, 1);
        add_request(3, 1, 2);
        add_request(4, 0, 2);
        wait_idle();

        // Oversized registers clamp to the full grid
        write_cfg(CFG_ROW_WIDTH, 63);
        write_cfg(CFG_ROW_COUNT, 127);
        add_request(200, 32, 2);
        add_request(201, 33, 1);
        add_request(202, 31, 1);
        wait_idle();

        // No rows in use
        write_cfg(CFG_ROW_WIDTH, 5);
        write_cfg(CFG_ROW_COUNT, 0);
        add_request(5, 1, 2);
        wait_idle();

        write_cfg(CFG_ROW_WIDTH, 1);
        write_cfg(CFG_ROW_COUNT, 64);
        add_request(6, 1, 16);
        add_request(0, 1, 1);
        wait_idle();

        // Random phases: the row window grows so fresh space keeps opening up
        for (ph = 0; ph < 10; ph++) begin
            idle_on = (ph < 8) && (ph % 3 != 2);
            rows = (ph == 9) ? 64 : 6 * (ph + 1);
            cols = (ph == 4) ? 32 : (ph == 7) ? 63 : $urandom_range(3, 16);
            write_cfg(CFG_ROW_WIDTH, cols);
            write_cfg(CFG_ROW_COUNT, rows);
            for (k = 0; k < 29; k++) begin
                id  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 255);
                sel = $urandom_range(0, 9);
                len = (sel < 8) ? $urandom_range(1, 6) :
                      (sel == 8) ? $urandom_range(0, 63) : $urandom_range(1, 32);
                sel = $urandom_range(0, 29);
                cnt = (sel < 20) ? $urandom_range(1, 3) :
                      (sel < 26) ? $urandom_range(4, 8) :
                      (sel < 29) ? $urandom_range(9, 16) : $urandom_range(0, 31);
                add_request(id, len, cnt);
            end
            wait_idle();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
design/gffp_pkg.sv
design/gffp_ctrl.sv
design/gffp_dp.sv
design/grid_first_fit_placer_core.sv
sim/tb_grid_first_fit_placer_core.sv
